// File: design/tkrt_pkg.sv
// Shared types, constants and the ranking compare for the top-k ranked table.
`default_nettype none
package tkrt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int SCORE_W = 16;
    localparam int TIME_W  = 16;
    localparam int TAG_W   = 32;
    localparam int INDEX_W = 4;
    localparam int RANK_W  = 5;
    localparam int FILL_W  = 5;
    localparam int ENTRY_W = SCORE_W + TIME_W + TAG_W;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic is_read;
    } t_cmd;

    // True if a stored entry stays ahead of a new record: higher score, or equal score
    // with an equal or lower time.
    function automatic logic stays_ahead(
        input logic [SCORE_W-1:0] a_score,
        input logic [TIME_W-1:0]  a_time,
        input logic [SCORE_W-1:0] b_score,
        input logic [TIME_W-1:0]  b_time
    );
        logic res;
        if (a_score != b_score) begin
            res = a_score > b_score;
        end else begin
            res = a_time <= b_time;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: design/top_k_ranked_table_insert_core.sv
// Top level of the top-k ranked table: keeps up to TABLE_DEPTH records in rank order.
// A result is held in the output register from the cycle after its input transaction is taken.
// One transaction per cycle while the sink keeps up; the compare-and-shift cells place a record in parallel.
// A new transaction is taken while the previous result is being drained by the sink.
// Reset (synchronous, active low) empties the table and the output register; cell contents
// are left as they are and are never read before they are written.
`default_nettype none
module top_k_ranked_table_insert_core #(
    parameter int TABLE_DEPTH = tkrt_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // score[15:0], time_tenths[31:16], tag[63:32], index[67:64], zeros above
    input  wire logic [tkrt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action[0]
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // accepted[0], rank[5:1], entry_valid[6], entry_score[22:7], entry_time[38:23],
    // entry_tag[70:39], fill_count[75:71], zeros above
    output logic      [tkrt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    tkrt_pkg::t_cmd cmd;

    tkrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_action    (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    tkrt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_score  (s_axis_tdata[15:0]),
        .i_time   (s_axis_tdata[31:16]),
        .i_tag    (s_axis_tdata[63:32]),
        .i_index  (s_axis_tdata[67:64]),
        .o_result (m_axis_tdata)
    );

endmodule
`default_nettype wire

// File: design/tkrt_ctrl.sv
// Controller for the top-k ranked table: input acceptance and output register occupancy.
`default_nettype none
module tkrt_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_action,
    input  wire logic        i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output tkrt_pkg::t_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_FULL  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    // A new transaction may enter when the output register is empty or is being drained.
    assign o_in_ready  = (r_state == ST_EMPTY) || i_out_ready;
    assign o_out_valid = (r_state == ST_FULL);
    assign take        = i_in_valid && o_in_ready;

    assign o_cmd.take_item = take;
    assign o_cmd.is_read   = (i_action == tkrt_pkg::ACT_READ);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EMPTY: begin
                if (take) n_state = ST_FULL;
            end
            ST_FULL: begin
                if (take) begin
                    n_state = ST_FULL;
                end else if (i_out_ready) begin
                    n_state = ST_EMPTY;
                end
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// File: design/tkrt_datapath.sv
// Datapath of the top-k ranked table: compare-and-shift cells, fill count and result register.
`default_nettype none
module tkrt_datapath #(
    parameter int TABLE_DEPTH = tkrt_pkg::DEF_TABLE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tkrt_pkg::t_cmd                   i_cmd,
    input  wire logic [tkrt_pkg::SCORE_W-1:0]     i_score,
    input  wire logic [tkrt_pkg::TIME_W-1:0]      i_time,
    input  wire logic [tkrt_pkg::TAG_W-1:0]       i_tag,
    input  wire logic [tkrt_pkg::INDEX_W-1:0]     i_index,
    output logic      [tkrt_pkg::OUT_DATA_W-1:0]  o_result
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PAD_W = tkrt_pkg::OUT_DATA_W - 2 - tkrt_pkg::RANK_W
                         - tkrt_pkg::SCORE_W - tkrt_pkg::TIME_W - tkrt_pkg::TAG_W
                         - tkrt_pkg::FILL_W;

    logic [tkrt_pkg::SCORE_W-1:0] r_cell_score [TABLE_DEPTH];
    logic [tkrt_pkg::TIME_W-1:0]  r_cell_time  [TABLE_DEPTH];
    logic [tkrt_pkg::TAG_W-1:0]   r_cell_tag   [TABLE_DEPTH];
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [tkrt_pkg::OUT_DATA_W-1:0] r_result;
    logic [tkrt_pkg::OUT_DATA_W-1:0] n_result;

    logic [TABLE_DEPTH-1:0] ahead;
    logic [TABLE_DEPTH-1:0] pos_oh;
    logic [CW-1:0]          pos;
    logic                   full;
    logic                   admit;
    logic                   do_insert;
    logic [tkrt_pkg::SCORE_W-1:0] rd_score;
    logic [tkrt_pkg::TIME_W-1:0]  rd_time;
    logic [tkrt_pkg::TAG_W-1:0]   rd_tag;
    logic                   rd_valid;
    logic [tkrt_pkg::RANK_W-1:0]  rank;

    // Every cell compares itself with the new record; valid entries are sorted, so the
    // cells that stay ahead form a prefix and the insert point is the first one that does not.
    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            ahead[i] = (CW'(i) < r_count) &&
                       tkrt_pkg::stays_ahead(r_cell_score[i], r_cell_time[i], i_score, i_time);
        end
        pos_oh[0] = !ahead[0];
        for (int i = 1; i < TABLE_DEPTH; i++) begin
            pos_oh[i] = !ahead[i] && ahead[i-1];
        end
        pos = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (pos_oh[i]) pos = pos | CW'(i);
        end
    end

    assign full      = (r_count == CW'(TABLE_DEPTH));
    assign admit     = !full || !ahead[TABLE_DEPTH-1];
    assign do_insert = i_cmd.take_item && !i_cmd.is_read && admit;
    assign rank      = tkrt_pkg::RANK_W'(pos + CW'(1));

    // Read port: a select over the cells at the requested position.
    always_comb begin
        rd_score = '0;
        rd_time  = '0;
        rd_tag   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (int'(i_index) == i) begin
                rd_score = r_cell_score[i];
                rd_time  = r_cell_time[i];
                rd_tag   = r_cell_tag[i];
            end
        end
    end

    always_comb begin
        if (CW > tkrt_pkg::INDEX_W) begin
            rd_valid = (CW'(i_index) < r_count);
        end else begin
            rd_valid = (i_index < tkrt_pkg::INDEX_W'(r_count));
        end
    end

    always_comb begin
        n_count = r_count;
        if (do_insert && !full) n_count = r_count + CW'(1);
    end

    always_comb begin
        n_result = '0;
        n_result[tkrt_pkg::OUT_DATA_W-PAD_W-1 -: tkrt_pkg::FILL_W] =
            tkrt_pkg::FILL_W'(n_count);
        if (i_cmd.is_read) begin
            if (rd_valid) begin
                n_result[6]     = 1'b1;
                n_result[22:7]  = rd_score;
                n_result[38:23] = rd_time;
                n_result[70:39] = rd_tag;
            end
        end else if (admit) begin
            n_result[0]   = 1'b1;
            n_result[5:1] = rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.take_item) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) r_result <= n_result;
    end

    // Compare-and-shift cells: keep, take the new record, or take the neighbour above.
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            if (!ahead[0]) begin
                r_cell_score[0] <= i_score;
                r_cell_time[0]  <= i_time;
                r_cell_tag[0]   <= i_tag;
            end
            for (int i = 1; i < TABLE_DEPTH; i++) begin
                if (pos_oh[i]) begin
                    r_cell_score[i] <= i_score;
                    r_cell_time[i]  <= i_time;
                    r_cell_tag[i]   <= i_tag;
                end else if (!ahead[i]) begin
                    r_cell_score[i] <= r_cell_score[i-1];
                    r_cell_time[i]  <= r_cell_time[i-1];
                    r_cell_tag[i]   <= r_cell_tag[i-1];
                end
            end
        end
    end

    assign o_result = r_result;

endmodule
`default_nettype wire
